// ===== hdl/fw3d_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fw3d_pkg - shared types and constants of the 3D Fenwick tree block
// Controller states, command and status bundles, field widths and codes.
// ----------------------------------------------------------------------------
package fw3d_pkg;

	localparam int SIDE_DEF    = 64;   // default cells per axis of storage
	localparam int COORD_W     = 6;    // width of each coordinate field
	localparam int GSIDE_W     = 7;    // width of the grid side register
	localparam int DATA_W      = 32;   // width of partial sums and results
	localparam logic [GSIDE_W-1:0] GSIDE_RESET = 7'd64;

	// request function codes
	localparam logic FUNC_ADD   = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_U_LOAD,
		ST_U_RD,
		ST_U_WR,
		ST_Q_LOAD,
		ST_Q_WALK,
		ST_Q_DONE
	} fw3d_state_t;

	// controller to datapath
	typedef struct packed {
		logic capture;      // latch request fields, reset accumulator and corner
		logic clr_step;     // write zero at the clearing address and advance
		logic load_upd;     // load walk indices from the update point
		logic load_corner;  // load walk indices from the current corner
		logic corner_next;  // advance to the next prefix corner
		logic step;         // advance the walk indices
		logic rd_upd;       // read the cell for read-modify-write
		logic wr_upd;       // write back cell plus delta
		logic q_read;       // read the cell into the accumulator
		logic res_load;     // move the accumulator into the result register
	} fw3d_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic req_query;    // function of the request on the input channel
		logic clr_last;     // clearing pass is at its final address
		logic upd_skip;     // update point lies outside the grid
		logic corner_skip;  // current corner has a negative bound
		logic corner_last;  // current corner is the eighth
		logic walk_last;    // walk indices are at the final cell
		logic out_free;     // result register can take a new value
	} fw3d_status_t;

endpackage

// ===== hdl/fw3d_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fw3d_if - request and result channels of the 3D Fenwick tree block
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface fw3d_req_if;
	logic                                valid;
	logic                                ready;
	logic                                func;
	logic [fw3d_pkg::COORD_W-1:0]        x_low;
	logic [fw3d_pkg::COORD_W-1:0]        y_low;
	logic [fw3d_pkg::COORD_W-1:0]        z_low;
	logic [fw3d_pkg::COORD_W-1:0]        x_high;
	logic [fw3d_pkg::COORD_W-1:0]        y_high;
	logic [fw3d_pkg::COORD_W-1:0]        z_high;
	logic signed [fw3d_pkg::DATA_W-1:0]  delta;

	modport source (output valid, func, x_low, y_low, z_low, x_high, y_high, z_high,
		delta, input ready);
	modport sink (input valid, func, x_low, y_low, z_low, x_high, y_high, z_high,
		delta, output ready);
endinterface

interface fw3d_rsp_if;
	logic                                valid;
	logic                                ready;
	logic signed [fw3d_pkg::DATA_W-1:0]  box_sum;

	modport source (output valid, box_sum, input ready);
	modport sink (input valid, box_sum, output ready);
endinterface

// ===== hdl/fenwick_3d_point_update_box_sum_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fenwick_3d_point_update_box_sum_top - 3D Fenwick tree, point add, box sum
// Partial sums over a cube of cells in one RAM, walked by a sequencer.
// ----------------------------------------------------------------------------
//  channel   dir   handshake            payload
//  req       in    req.valid/req.ready  func, x/y/z_low, x/y/z_high, delta
//  rsp       out   rsp.valid/rsp.ready  box_sum (queries only)
//  cfg       in    cfg_we               cfg_wdata = grid_side
//
//  Update: a read, then a write back, for each touched cell. Query: a read
//  of each cell on the chains of each non-empty prefix corner; the single
//  RAM read port serializes both. After reset a clearing pass writes zero
//  to all 2^(3*clog2(SIDE)) words, one a cycle, with req.ready low. A held
//  result stalls only the end of the next query; the next request is taken
//  while the result waits.
// ----------------------------------------------------------------------------
module fenwick_3d_point_update_box_sum_top #(
	parameter int SIDE = fw3d_pkg::SIDE_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [fw3d_pkg::GSIDE_W-1:0] cfg_wdata,
	fw3d_req_if.sink                     req,
	fw3d_rsp_if.source                   rsp
);

	fw3d_pkg::fw3d_cmd_t    cmd;
	fw3d_pkg::fw3d_status_t st;
	logic                   req_ready;

	assign req.ready = req_ready;

	fw3d_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req_ready),
		.st        (st),
		.cmd       (cmd)
	);

	fw3d_dp #(
		.SIDE (SIDE)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.st         (st),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.req_func   (req.func),
		.req_x_low  (req.x_low),
		.req_y_low  (req.y_low),
		.req_z_low  (req.z_low),
		.req_x_high (req.x_high),
		.req_y_high (req.y_high),
		.req_z_high (req.z_high),
		.req_delta  (req.delta),
		.rsp        (rsp)
	);

endmodule

// ===== hdl/fw3d_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fw3d_ram - generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module fw3d_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write, then register the read word
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== hdl/fw3d_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fw3d_ctrl - sequencer of the 3D Fenwick tree block
// Runs the clearing pass, the update read-modify-write walk and the
// eight-corner query walk, and hands the result to the output register.
// ----------------------------------------------------------------------------
module fw3d_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   req_valid,
	output logic                   req_ready,
	input  fw3d_pkg::fw3d_status_t st,
	output fw3d_pkg::fw3d_cmd_t    cmd
);

	fw3d_pkg::fw3d_state_t state_q, state_nxt;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fw3d_pkg::ST_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state and commands
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		case (state_q)
			fw3d_pkg::ST_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (st.clr_last) begin
					state_nxt = fw3d_pkg::ST_IDLE;
				end
			end
			fw3d_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_nxt   = (st.req_query == fw3d_pkg::FUNC_QUERY) ?
						fw3d_pkg::ST_Q_LOAD : fw3d_pkg::ST_U_LOAD;
				end
			end
			fw3d_pkg::ST_U_LOAD: begin
				if (st.upd_skip) begin
					state_nxt = fw3d_pkg::ST_IDLE;
				end else begin
					cmd.load_upd = 1'b1;
					state_nxt    = fw3d_pkg::ST_U_RD;
				end
			end
			fw3d_pkg::ST_U_RD: begin
				cmd.rd_upd = 1'b1;
				state_nxt  = fw3d_pkg::ST_U_WR;
			end
			fw3d_pkg::ST_U_WR: begin
				cmd.wr_upd = 1'b1;
				cmd.step   = 1'b1;
				state_nxt  = st.walk_last ? fw3d_pkg::ST_IDLE : fw3d_pkg::ST_U_RD;
			end
			fw3d_pkg::ST_Q_LOAD: begin
				if (st.corner_skip) begin
					cmd.corner_next = 1'b1;
					if (st.corner_last) begin
						state_nxt = fw3d_pkg::ST_Q_DONE;
					end
				end else begin
					cmd.load_corner = 1'b1;
					state_nxt       = fw3d_pkg::ST_Q_WALK;
				end
			end
			fw3d_pkg::ST_Q_WALK: begin
				cmd.q_read = 1'b1;
				cmd.step   = 1'b1;
				if (st.walk_last) begin
					cmd.corner_next = 1'b1;
					state_nxt       = st.corner_last ? fw3d_pkg::ST_Q_DONE :
						fw3d_pkg::ST_Q_LOAD;
				end
			end
			fw3d_pkg::ST_Q_DONE: begin
				if (st.out_free) begin
					cmd.res_load = 1'b1;
					state_nxt    = fw3d_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = fw3d_pkg::ST_IDLE;
			end
		endcase
	end

	// no request is taken before the storage has been cleared
	a_no_req_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == fw3d_pkg::ST_CLEAR) |-> !cmd.capture)
		else $error("request taken during clearing pass");

	// a result is loaded only after a query state
	a_walk_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.res_load) |-> ($past(state_q) == fw3d_pkg::ST_Q_DONE ||
		$past(state_q) == fw3d_pkg::ST_Q_WALK || $past(state_q) == fw3d_pkg::ST_Q_LOAD))
		else $error("result loaded outside a query");

endmodule

// ===== hdl/fw3d_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fw3d_dp - datapath of the 3D Fenwick tree block
// Request registers, corner clamping, walk index counters, partial-sum RAM,
// accumulator and result register.
// ----------------------------------------------------------------------------
module fw3d_dp #(
	parameter int SIDE = fw3d_pkg::SIDE_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  fw3d_pkg::fw3d_cmd_t                cmd,
	output fw3d_pkg::fw3d_status_t             st,
	input  logic                               cfg_we,
	input  logic [fw3d_pkg::GSIDE_W-1:0]       cfg_wdata,
	input  logic                               req_func,
	input  logic [fw3d_pkg::COORD_W-1:0]       req_x_low,
	input  logic [fw3d_pkg::COORD_W-1:0]       req_y_low,
	input  logic [fw3d_pkg::COORD_W-1:0]       req_z_low,
	input  logic [fw3d_pkg::COORD_W-1:0]       req_x_high,
	input  logic [fw3d_pkg::COORD_W-1:0]       req_y_high,
	input  logic [fw3d_pkg::COORD_W-1:0]       req_z_high,
	input  logic signed [fw3d_pkg::DATA_W-1:0] req_delta,
	fw3d_rsp_if.source                         rsp
);

	localparam int CW    = $clog2(SIDE);
	localparam int EW    = (CW + 1 > fw3d_pkg::GSIDE_W) ? CW + 1 : fw3d_pkg::GSIDE_W;
	localparam int AW    = 3 * CW;
	localparam int DEPTH = 2 ** AW;
	localparam int DW    = fw3d_pkg::DATA_W;

	// clamped corner bound: top bit set when the bound is negative
	typedef logic [CW:0] bound_t;

	logic [fw3d_pkg::GSIDE_W-1:0] gside_q;
	logic [EW-1:0]                eff_ew;
	logic [CW:0]                  eff;

	logic                         func_q;
	logic [fw3d_pkg::COORD_W-1:0] xl_q, yl_q, zl_q, xh_q, yh_q, zh_q;
	logic [DW-1:0]                delta_q;

	bound_t   bxl, byl, bzl, bxh, byh, bzh;
	bound_t   cx, cy, cz;
	logic [2:0] corner_q;
	logic     q_sign_q;

	logic [CW:0] i_q, j_q, k_q, j0_q, k0_q;
	logic [CW:0] i_nxt, j_nxt, k_nxt;
	logic        i_last, j_last, k_last;

	logic [AW-1:0] clr_q;
	logic [AW-1:0] addr;
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [DW-1:0] ram_wdata;
	logic [DW-1:0] ram_rdata;

	logic          rd_pend_s1;
	logic          rd_sign_s1;
	logic [DW-1:0] acc_q, acc_nxt;
	logic          out_valid_q;
	logic [DW-1:0] out_data_q;

	// clamp a corner bound to the grid, low corners are taken one below
	function automatic bound_t clamp_bound(input logic [fw3d_pkg::COORD_W-1:0] v,
		input logic lo, input logic [EW-1:0] n);
		logic [EW-1:0] ve;
		bound_t        b;
		ve = lo ? (EW'(v) - EW'(1)) : EW'(v);
		b  = '0;
		if (lo && (v == '0)) begin
			b[CW] = 1'b1;
		end else if (ve >= n) begin
			if (n == '0) begin
				b[CW] = 1'b1;
			end else begin
				b[CW-1:0] = ve[CW-1:0] - ve[CW-1:0] + n[CW-1:0] - CW'(1);
			end
		end else begin
			b[CW-1:0] = ve[CW-1:0];
		end
		return b;
	endfunction

	// one step along a chain: update walks up, query walks down
	function automatic logic [CW+1:0] chain_next(input logic [CW:0] v, input logic query,
		input logic [CW:0] n);
		logic [CW:0] up;
		logic [CW:0] dn;
		logic        last;
		up = v | (v + (CW+1)'(1));
		dn = v & (v + (CW+1)'(1));
		if (query) begin
			last = (dn == '0);
			return {last, dn - (CW+1)'(1)};
		end
		last = (up >= n);
		return {last, up};
	endfunction

	// grid side register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gside_q <= fw3d_pkg::GSIDE_RESET;
		end else if (cfg_we) begin
			gside_q <= cfg_wdata;
		end
	end

	assign eff_ew = (EW'(gside_q) < EW'(SIDE)) ? EW'(gside_q) : EW'(SIDE);
	assign eff    = eff_ew[CW:0];

	// hold the request fields
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q  <= req_func;
			xl_q    <= req_x_low;
			yl_q    <= req_y_low;
			zl_q    <= req_z_low;
			xh_q    <= req_x_high;
			yh_q    <= req_y_high;
			zh_q    <= req_z_high;
			delta_q <= $unsigned(req_delta);
		end
	end

	// corner bounds and corner selection
	assign bxl = clamp_bound(xl_q, 1'b1, eff_ew);
	assign byl = clamp_bound(yl_q, 1'b1, eff_ew);
	assign bzl = clamp_bound(zl_q, 1'b1, eff_ew);
	assign bxh = clamp_bound(xh_q, 1'b0, eff_ew);
	assign byh = clamp_bound(yh_q, 1'b0, eff_ew);
	assign bzh = clamp_bound(zh_q, 1'b0, eff_ew);

	assign cx = corner_q[0] ? bxl : bxh;
	assign cy = corner_q[1] ? byl : byh;
	assign cz = corner_q[2] ? bzl : bzh;

	// corner counter, advance through the eight prefix sums
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			corner_q <= '0;
		end else if (cmd.capture) begin
			corner_q <= '0;
		end else if (cmd.corner_next) begin
			corner_q <= corner_q + 3'd1;
		end
	end

	// chain steps for the three axes
	always_comb begin
		logic [CW+1:0] ni, nj, nk;
		ni = chain_next(i_q, func_q, eff);
		nj = chain_next(j_q, func_q, eff);
		nk = chain_next(k_q, func_q, eff);
		i_last = ni[CW+1];
		j_last = nj[CW+1];
		k_last = nk[CW+1];
		i_nxt  = ni[CW:0];
		j_nxt  = nj[CW:0];
		k_nxt  = nk[CW:0];
	end

	// walk indices: innermost axis first, reload inner axes on carry
	always_ff @(posedge clk) begin
		if (cmd.load_upd) begin
			i_q  <= (CW+1)'(xl_q);
			j_q  <= (CW+1)'(yl_q);
			k_q  <= (CW+1)'(zl_q);
			j0_q <= (CW+1)'(yl_q);
			k0_q <= (CW+1)'(zl_q);
		end else if (cmd.load_corner) begin
			i_q      <= {1'b0, cx[CW-1:0]};
			j_q      <= {1'b0, cy[CW-1:0]};
			k_q      <= {1'b0, cz[CW-1:0]};
			j0_q     <= {1'b0, cy[CW-1:0]};
			k0_q     <= {1'b0, cz[CW-1:0]};
			q_sign_q <= ^corner_q;
		end else if (cmd.step) begin
			if (!k_last) begin
				k_q <= k_nxt;
			end else if (!j_last) begin
				j_q <= j_nxt;
				k_q <= k0_q;
			end else if (!i_last) begin
				i_q <= i_nxt;
				j_q <= j0_q;
				k_q <= k0_q;
			end
		end
	end

	// clearing address counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr_step) begin
			clr_q <= clr_q + AW'(1);
		end
	end

	// partial-sum storage
	assign addr      = {i_q[CW-1:0], j_q[CW-1:0], k_q[CW-1:0]};
	assign ram_we    = cmd.clr_step | cmd.wr_upd;
	assign ram_waddr = cmd.clr_step ? clr_q : addr;
	assign ram_wdata = cmd.clr_step ? '0 : (ram_rdata + delta_q);

	fw3d_ram #(
		.WIDTH (DW),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (addr),
		.rdata (ram_rdata)
	);

	// track query reads whose data arrives next cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_pend_s1 <= 1'b0;
		end else begin
			rd_pend_s1 <= cmd.q_read;
		end
	end

	always_ff @(posedge clk) begin
		rd_sign_s1 <= q_sign_q;
	end

	// accumulate with inclusion-exclusion sign
	always_comb begin
		acc_nxt = acc_q;
		if (rd_pend_s1) begin
			acc_nxt = rd_sign_s1 ? (acc_q - ram_rdata) : (acc_q + ram_rdata);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			acc_q <= '0;
		end else begin
			acc_q <= acc_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.res_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			out_data_q <= acc_nxt;
		end
	end

	assign rsp.valid   = out_valid_q;
	assign rsp.box_sum = $signed(out_data_q);

	// status back to the controller
	assign st.req_query   = req_func;
	assign st.clr_last    = &clr_q;
	assign st.upd_skip    = (EW'(xl_q) >= eff_ew) || (EW'(yl_q) >= eff_ew) ||
		(EW'(zl_q) >= eff_ew);
	assign st.corner_skip = cx[CW] | cy[CW] | cz[CW];
	assign st.corner_last = (corner_q == 3'd7);
	assign st.walk_last   = i_last & j_last & k_last;
	assign st.out_free    = !out_valid_q || rsp.ready;

	// write-back always follows the read of the same cell
	a_rmw_order: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_upd |-> $past(cmd.rd_upd))
		else $error("update write without preceding read");

	// query read data is never overlapped by a storage write
	a_no_wr_pend: assert property (@(posedge clk) disable iff (!arst_n)
		rd_pend_s1 |-> (!cmd.wr_upd && !cmd.clr_step))
		else $error("storage written while query data pending");

	// a result appears only when the controller loads one
	a_res_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(cmd.res_load))
		else $error("result valid without load");

	// query reads only come from corners with non-negative bounds
	a_read_corner: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.q_read |-> !st.corner_skip)
		else $error("read issued for an empty corner");

endmodule

// ===== verif/fw3d_sum_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fw3d_sum_checker - box sum predictor and scoreboard for the 3D Fenwick tree
// Watches the request, result and grid side write ports. It keeps its own copy
// of the partial sum cube, queues the sum each query should return, and
// compares every result taken from the block against the oldest one waiting.
// ----------------------------------------------------------------------------
module fw3d_sum_checker
	import fw3d_pkg::*;
#(
	parameter int SIDE = SIDE_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [GSIDE_W-1:0] cfg_wdata,
	fw3d_req_if                req,
	fw3d_rsp_if                rsp,
	output int                 fail_count,
	output int                 pending
);

	localparam int CELLS = SIDE * SIDE * SIDE;

	logic [DATA_W-1:0]  tree_cells [CELLS];
	logic [DATA_W-1:0]  sum_queue [$];
	logic [GSIDE_W-1:0] side_reg;
	int                 fails;
	int                 reports;

	// cells per axis in use: the register, limited to the storage side
	function automatic int side_in_use();
		return (int'(side_reg) < SIDE) ? int'(side_reg) : SIDE;
	endfunction

	// add a delta along the i | (i+1) chains of all three axes
	function automatic void add_point(input int x, input int y, input int z,
		input logic [DATA_W-1:0] d);
		int n;
		int i;
		int j;
		int k;
		n = side_in_use();
		for (i = x; i < n; i = i | (i + 1))
			for (j = y; j < n; j = j | (j + 1))
				for (k = z; k < n; k = k | (k + 1))
					tree_cells[(i * SIDE + j) * SIDE + k] += d;
	endfunction

	// sum over the box from the origin to a corner clamped to the grid
	function automatic logic [DATA_W-1:0] prefix_sum(input int x, input int y, input int z);
		int n;
		int i;
		int j;
		int k;
		logic [DATA_W-1:0] acc;
		n = side_in_use();
		acc = '0;
		if (x >= n) x = n - 1;
		if (y >= n) y = n - 1;
		if (z >= n) z = n - 1;
		for (i = x; i >= 0; i = (i & (i + 1)) - 1)
			for (j = y; j >= 0; j = (j & (j + 1)) - 1)
				for (k = z; k >= 0; k = (k & (k + 1)) - 1)
					acc += tree_cells[(i * SIDE + j) * SIDE + k];
		return acc;
	endfunction

	// combine eight prefix sums; no reordering when low lies above high
	function automatic logic [DATA_W-1:0] box_sum_of(input int xl, input int yl, input int zl,
		input int xh, input int yh, input int zh);
		xl = xl - 1;
		yl = yl - 1;
		zl = zl - 1;
		return prefix_sum(xh, yh, zh)
			- prefix_sum(xl, yh, zh) - prefix_sum(xh, yl, zh) + prefix_sum(xl, yl, zh)
			- prefix_sum(xh, yh, zl) + prefix_sum(xl, yh, zl) + prefix_sum(xh, yl, zl)
			- prefix_sum(xl, yl, zl);
	endfunction

	// check results, track the register, predict each accepted request
	always @(posedge clk or negedge arst_n) begin : watch
		logic [DATA_W-1:0] want;
		if (!arst_n) begin
			for (int a = 0; a < CELLS; a++)
				tree_cells[a] = '0;
			sum_queue.delete();
			side_reg = GSIDE_RESET;
			fails = 0;
			reports = 0;
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (sum_queue.size() == 0) begin
					fails++;
					if (reports < 10) begin
						reports++;
						$display("%t: box sum %0d arrived with nothing expected",
							$realtime, rsp.box_sum);
					end
				end else begin
					want = sum_queue.pop_front();
					if (rsp.box_sum !== want) begin
						fails++;
						if (reports < 10) begin
							reports++;
							$display("%t: box sum mismatch: expected %0d, got %0d",
								$realtime, $signed(want), rsp.box_sum);
						end
					end
				end
			end
			if (cfg_we)
				side_reg = cfg_wdata;
			if (req.valid && req.ready) begin
				if (req.func == FUNC_QUERY)
					sum_queue.push_back(box_sum_of(int'(req.x_low), int'(req.y_low),
						int'(req.z_low), int'(req.x_high), int'(req.y_high),
						int'(req.z_high)));
				else
					add_point(int'(req.x_low), int'(req.y_low), int'(req.z_low), req.delta);
			end
			fail_count <= fails;
			pending <= sum_queue.size();
		end
	end

endmodule

// ===== verif/fenwick_3d_point_update_box_sum_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fenwick_3d_point_update_box_sum_top_test - test top of the 3D Fenwick tree
// Resets the block, sends directed point adds and box queries at the corners
// of the grid and at several grid sides, then random requests over a series
// of grid sides. Both channels idle at random; the result side also holds off
// for a long stretch. The checker predicts and compares every box sum.
// ----------------------------------------------------------------------------
module fenwick_3d_point_update_box_sum_top_test;
	import fw3d_pkg::*;

	localparam int CLK_HALF      = 4;
	localparam int IDLE_PCT      = 11;
	localparam int SETTLE_CYCLES = 800;
	localparam longint TIMEOUT_NS = 64'd24_000_000;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [GSIDE_W-1:0] cfg_wdata;
	int                 fail_count;
	int                 pending;

	bit                 calm;        // no idling on either side
	bit                 stall_ask;   // ask the result side for a long hold-off
	int                 stall_len;
	int                 stall_left;

	fw3d_req_if req_ch ();
	fw3d_rsp_if rsp_ch ();

	fenwick_3d_point_update_box_sum_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	fw3d_sum_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.req        (req_ch),
		.rsp        (rsp_ch),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// clock, 8 ns period
	always begin
		clk = 1'b0;
		#(CLK_HALF);
		clk = 1'b1;
		#(CLK_HALF);
	end

	// result side: random idling, or a counted hold-off when asked
	initial begin
		rsp_ch.ready = 1'b0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				rsp_ch.ready <= 1'b0;
				stall_left--;
			end else if (stall_ask) begin
				stall_ask = 1'b0;
				stall_left = stall_len - 1;
				rsp_ch.ready <= 1'b0;
			end else if (calm) begin
				rsp_ch.ready <= 1'b1;
			end else begin
				rsp_ch.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
			end
		end
	end

	// offer one request after a random gap and hold it until taken
	task automatic send_req(input logic f,
		input logic [COORD_W-1:0] xl, input logic [COORD_W-1:0] yl,
		input logic [COORD_W-1:0] zl, input logic [COORD_W-1:0] xh,
		input logic [COORD_W-1:0] yh, input logic [COORD_W-1:0] zh,
		input logic [DATA_W-1:0] d);
		@(negedge clk);
		if (!calm) begin
			while ($urandom_range(0, 99) < IDLE_PCT) begin
				req_ch.valid <= 1'b0;
				@(negedge clk);
			end
		end
		req_ch.valid  <= 1'b1;
		req_ch.func   <= f;
		req_ch.x_low  <= xl;
		req_ch.y_low  <= yl;
		req_ch.z_low  <= zl;
		req_ch.x_high <= xh;
		req_ch.y_high <= yh;
		req_ch.z_high <= zh;
		req_ch.delta  <= d;
		do
			@(posedge clk);
		while (!req_ch.ready);
	endtask

	// drop valid and wait for every expected box sum
	task automatic drain();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (pending != 0)
			@(posedge clk);
	endtask

	// drain, then let a trailing point add finish
	task automatic settle();
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// write the grid side while the block is idle
	task automatic set_side(input logic [GSIDE_W-1:0] v);
		settle();
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	// coordinate mostly inside the grid, sometimes anywhere in the field
	function automatic logic [COORD_W-1:0] pick_coord(input int n);
		if (n > 0 && $urandom_range(0, 99) < 85)
			return COORD_W'($urandom_range(0, n - 1));
		return COORD_W'($urandom_range(0, 63));
	endfunction

	// random mix of point adds and box queries at one grid side
	task automatic run_random(input int side_val, input int count, input int query_pct,
		input int pause_at);
		int n;
		int k;
		logic f;
		logic [COORD_W-1:0] lo [3];
		logic [COORD_W-1:0] hi [3];
		logic [COORD_W-1:0] t;
		logic [DATA_W-1:0] d;
		n = (side_val < SIDE_DEF) ? side_val : SIDE_DEF;
		for (k = 0; k < count; k++) begin
			if (k == pause_at)
				drain();
			f = ($urandom_range(0, 99) < query_pct) ? FUNC_QUERY : FUNC_ADD;
			for (int ax = 0; ax < 3; ax++) begin
				lo[ax] = pick_coord(n);
				hi[ax] = pick_coord(n);
				// keep most boxes ordered, leave some with low above high
				if (f == FUNC_QUERY && lo[ax] > hi[ax] && $urandom_range(0, 99) < 80) begin
					t = lo[ax];
					lo[ax] = hi[ax];
					hi[ax] = t;
				end
			end
			if ($urandom_range(0, 1) != 0)
				d = $urandom;
			else
				d = DATA_W'($urandom_range(0, 200)) - DATA_W'(100);
			send_req(f, lo[0], lo[1], lo[2], hi[0], hi[1], hi[2], d);
		end
	endtask

	// stimulus and verdict
	initial begin
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_wdata     = GSIDE_RESET;
		calm          = 1'b0;
		stall_ask     = 1'b0;
		stall_len     = 0;
		req_ch.valid  = 1'b0;
		req_ch.func   = FUNC_ADD;
		req_ch.x_low  = '0;
		req_ch.y_low  = '0;
		req_ch.z_low  = '0;
		req_ch.x_high = '0;
		req_ch.y_high = '0;
		req_ch.z_high = '0;
		req_ch.delta  = '0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		// corners of the full grid, extreme deltas, wrapping sums
		send_req(FUNC_ADD, 0, 0, 0, 0, 0, 0, 32'd1);
		send_req(FUNC_ADD, 63, 63, 63, 63, 63, 63, 32'h7FFF_FFFF);
		send_req(FUNC_ADD, 63, 0, 31, 0, 63, 0, 32'h8000_0000);
		send_req(FUNC_ADD, 5, 9, 17, 42, 21, 60, 32'hFFFF_FFFF);
		send_req(FUNC_QUERY, 0, 0, 0, 63, 63, 63, 32'hFFFF_FFFF);
		send_req(FUNC_QUERY, 0, 0, 0, 0, 0, 0, 32'h0);
		send_req(FUNC_QUERY, 63, 63, 63, 63, 63, 63, 32'h8000_0000);
		// low above high on two axes
		send_req(FUNC_QUERY, 40, 20, 50, 3, 63, 10, 32'h1234_5678);

		// small grid: points outside it, box clipped to it
		set_side(7'd4);
		send_req(FUNC_ADD, 3, 3, 3, 0, 0, 0, 32'd7);
		send_req(FUNC_ADD, 4, 1, 1, 0, 0, 0, 32'd100);
		send_req(FUNC_ADD, 1, 63, 2, 0, 0, 0, 32'd5);
		send_req(FUNC_QUERY, 0, 0, 0, 63, 63, 63, 32'd0);
		send_req(FUNC_QUERY, 2, 2, 2, 1, 1, 1, 32'd0);

		// empty grid: adds change nothing, queries give zero
		set_side(7'd0);
		send_req(FUNC_ADD, 0, 0, 0, 0, 0, 0, 32'd9);
		send_req(FUNC_QUERY, 0, 0, 0, 63, 63, 63, 32'd0);

		// side above the storage: limited to the full cube, sums kept
		set_side(7'd127);
		send_req(FUNC_QUERY, 0, 0, 0, 63, 63, 63, 32'd0);
		send_req(FUNC_ADD, 62, 1, 0, 5, 5, 5, 32'hFFFF_FFFB);
		send_req(FUNC_QUERY, 1, 0, 0, 63, 63, 63, 32'd0);

		// single cell grid
		set_side(7'd1);
		send_req(FUNC_QUERY, 0, 0, 0, 0, 0, 0, 32'd0);
		send_req(FUNC_QUERY, 0, 0, 0, 63, 63, 63, 32'd0);

		// random phases; long result hold-off while requests keep coming
		set_side(7'd8);
		stall_len = 600;
		stall_ask = 1'b1;
		run_random(8, 30, 60, -1);
		set_side(7'd3);
		run_random(3, 20, 50, -1);
		set_side(7'd16);
		calm = 1'b1;
		run_random(16, 30, 50, -1);
		calm = 1'b0;
		set_side(7'd1);
		run_random(1, 12, 50, -1);
		set_side(7'd5);
		run_random(5, 25, 50, -1);
		set_side(7'd2);
		run_random(2, 15, 50, -1);
		set_side(7'd13);
		run_random(13, 25, 50, 12);
		set_side(7'd33);
		run_random(33, 12, 50, -1);
		set_side(7'd127);
		run_random(127, 6, 50, -1);
		set_side(7'd64);
		run_random(64, 6, 50, -1);
		set_side(7'd0);
		run_random(0, 6, 50, -1);
		set_side(7'd7);
		run_random(7, 25, 50, -1);

		settle();
		if (fail_count == 0 && pending == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// guard against a hung block
	initial begin
		#(TIMEOUT_NS);
		$display("FAILED: results differ");
		$finish;
	end

endmodule
